### src/nfbsa_pkg.sv
// ----------------------------------------------------------------------------
// nfbsa_pkg
// Shared widths, codes, state type and control struct of the next-fit
// bitmap slot allocator.
// ----------------------------------------------------------------------------
package nfbsa_pkg;

    localparam int HANDLE_W   = 13;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int WORD_BITS = 8;
    localparam int BIT_W     = 3;
    localparam logic [WORD_BITS-1:0] WORD_ONES = 8'hFF;

    localparam int RESET_REGION0 = 4096;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION1 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RD,
        ST_EVAL,
        ST_FRD,
        ST_FWR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

### src/nfbsa_if.sv
// ----------------------------------------------------------------------------
// nfbsa channel interfaces
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------
interface nfbsa_in_if;
    logic                            valid;
    logic                            ready;
    logic [nfbsa_pkg::MODE_W-1:0]    mode;
    logic [nfbsa_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, mode, handle, input ready);
    modport sink   (input valid, mode, handle, output ready);
endinterface

interface nfbsa_out_if;
    logic                            valid;
    logic                            ready;
    logic [nfbsa_pkg::HANDLE_W-1:0]  result_handle;
    logic [nfbsa_pkg::STATUS_W-1:0]  status;

    modport source (output valid, result_handle, status, input ready);
    modport sink   (input valid, result_handle, status, output ready);
endinterface

interface nfbsa_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [nfbsa_pkg::CFG_IDX_W-1:0]   index;
    logic [nfbsa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/nfbsa_bit_unit.sv
// ----------------------------------------------------------------------------
// nfbsa_bit_unit
// Shared word unit: finds the lowest free bit of a masked bitmap word and
// returns the word with one bit cleared (take) or set (release).
// ----------------------------------------------------------------------------
module nfbsa_bit_unit (
    input  logic [nfbsa_pkg::WORD_BITS-1:0] i_data,
    input  logic [nfbsa_pkg::WORD_BITS-1:0] i_mask,
    input  logic [nfbsa_pkg::BIT_W-1:0]     i_bit,
    input  logic                            i_set,
    output logic                            o_hit,
    output logic [nfbsa_pkg::BIT_W-1:0]     o_hit_bit,
    output logic [nfbsa_pkg::WORD_BITS-1:0] o_data
);
    import nfbsa_pkg::*;

    logic [WORD_BITS-1:0] cand;
    logic [BIT_W-1:0]     sel;

    always_comb begin
        cand      = i_data & i_mask;
        o_hit     = |cand;
        o_hit_bit = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                o_hit_bit = BIT_W'(k);
            end
        end
        sel         = i_set ? i_bit : o_hit_bit;
        o_data      = i_data;
        o_data[sel] = i_set;
    end

endmodule

### src/nfbsa_bitmap.sv
// ----------------------------------------------------------------------------
// nfbsa_bitmap
// Single-port free map storage, one bitmap word per row, registered read.
// ----------------------------------------------------------------------------
module nfbsa_bitmap #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                            i_clk,
    input  nfbsa_pkg::t_mem_ctl             i_ctl,
    input  logic [AW-1:0]                   i_addr,
    input  logic [nfbsa_pkg::WORD_BITS-1:0] i_wdata,
    output logic [nfbsa_pkg::WORD_BITS-1:0] o_rdata
);
    import nfbsa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/next_fit_bitmap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// next_fit_bitmap_slot_allocator_top
// Next-fit slot allocator over two regions with a word-wide free bitmap.
//
//   channel  dir  payload                  word moved when
//   i_in     in   mode, handle             valid & ready
//   o_res    out  result_handle, status    valid & ready
//   i_cfg    in   index, data              valid & ready
//
// Alloc: reads (ST_RD) and evaluates (ST_EVAL) one 8-slot bitmap word after another
//   until a hit or the start word comes round again; one shared single-port bitmap RAM and word unit set the pace.
// Free: reads the row (ST_FRD) and writes it back with the bit set (ST_FWR); a handle
//   out of range or an unused mode goes straight to ST_DONE. Clear: one RAM row per cycle, REGIONS*REGION_SLOTS/8 rows.
// Reset runs a clearing pass over REGIONS*REGION_SLOTS/8 rows (1024 by
//   default); a size write sweeps its region, REGION_SLOTS/8 rows.
// A finished word waits in the output register; a new request is taken
//   meanwhile and stalls only at its own end.
// ----------------------------------------------------------------------------
module next_fit_bitmap_slot_allocator_top #(
    parameter int REGION_SLOTS = 4096,
    parameter int REGIONS      = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nfbsa_in_if.sink           i_in,
    nfbsa_out_if.source        o_res,
    nfbsa_cfg_if.sink          i_cfg
);
    import nfbsa_pkg::*;

    localparam int ROWS  = (REGION_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = REGIONS * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLW   = $clog2(REGION_SLOTS);
    localparam int SZW   = SLW + 1;
    localparam int RST_SIZE0 = (REGION_SLOTS < RESET_REGION0) ? REGION_SLOTS : RESET_REGION0;

    t_state                r_state, n_state;
    logic [SZW-1:0]        r_size0, n_size0;
    logic [SZW-1:0]        r_size1, n_size1;
    logic                  r_cur_reg, n_cur_reg;
    logic [SLW-1:0]        r_cur_slot, n_cur_slot;
    logic                  r_reg, n_reg;
    logic [WW-1:0]         r_word, n_word;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic                  r_sreg, n_sreg;
    logic [WW-1:0]         r_sword, n_sword;
    logic                  r_first, n_first;
    logic                  r_last, n_last;
    logic [HANDLE_W-1:0]   r_res_handle, n_res_handle;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [AW-1:0]         r_swp_addr, n_swp_addr;
    logic [AW-1:0]         r_swp_end, n_swp_end;
    logic                  r_swp_full, n_swp_full;
    logic                  r_swp_done, n_swp_done;

    logic                  in_acc, cfg_acc, out_load;
    logic                  use1;
    logic [SLW-1:0]        last0, last1;
    logic [WW-1:0]         lw0, lw1, lw_cur;
    logic [BIT_W-1:0]      lb_cur;
    logic [SZW-1:0]        cur_size, cur_nxt;
    logic                  st_wrap, st_reg;
    logic [SLW-1:0]        st_slot;
    logic [WORD_BITS-1:0]  scan_mask;
    logic                  nx_reg, nx_last;
    logic [WW-1:0]         nx_word;
    logic [SZW:0]          total;
    logic                  fr_bad, fr_reg;
    logic [SLW-1:0]        fr_slot;
    logic [SLW-1:0]        hit_slot;
    logic [HANDLE_W-1:0]   hit_handle;
    logic [SZW-1:0]        cfg_size0, cfg_size1;

    t_mem_ctl              mem_ctl;
    logic [AW-1:0]         mem_addr, scan_addr;
    logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;
    logic [WORD_BITS-1:0]  u_mask, u_data;
    logic                  u_set, u_hit;
    logic [BIT_W-1:0]      u_hit_bit;

    nfbsa_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    nfbsa_bit_unit u_unit (
        .i_data    (mem_rdata),
        .i_mask    (u_mask),
        .i_bit     (r_bit),
        .i_set     (u_set),
        .o_hit     (u_hit),
        .o_hit_bit (u_hit_bit),
        .o_data    (u_data)
    );

    // handshake
    assign i_in.ready          = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready         = (r_state == ST_IDLE) || ((r_state == ST_SWEEP) && r_swp_full);
    assign in_acc              = i_in.valid && i_in.ready;
    assign cfg_acc             = i_cfg.valid && i_cfg.ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.result_handle = r_out_handle;
    assign o_res.status        = r_out_status;

    // region geometry
    always_comb begin
        use1     = (REGIONS >= 2) && (r_size1 != '0);
        last0    = SLW'(r_size0 - SZW'(1));
        last1    = SLW'(r_size1 - SZW'(1));
        lw0      = WW'(last0 >> BIT_W);
        lw1      = WW'(last1 >> BIT_W);
        lw_cur   = r_reg ? lw1 : lw0;
        lb_cur   = r_reg ? last1[BIT_W-1:0] : last0[BIT_W-1:0];
        total    = {1'b0, r_size0} + {1'b0, r_size1};

        cur_size = r_cur_reg ? r_size1 : r_size0;
        cur_nxt  = SZW'({1'b0, r_cur_slot}) + SZW'(1);
        st_wrap  = cur_nxt >= cur_size;
        st_reg   = st_wrap ? (!r_cur_reg && use1) : r_cur_reg;
        st_slot  = st_wrap ? '0 : SLW'(cur_nxt);

        for (int k = 0; k < WORD_BITS; k++) begin
            scan_mask[k] = ((r_word != lw_cur) || (BIT_W'(k) <= lb_cur))
                        && (!r_first || (BIT_W'(k) >= r_bit))
                        && (!r_last || (BIT_W'(k) < r_bit));
        end

        if (r_word == lw_cur) begin
            nx_word = '0;
            nx_reg  = !r_reg && use1;
        end else begin
            nx_word = r_word + WW'(1);
            nx_reg  = r_reg;
        end
        nx_last = (nx_reg == r_sreg) && (nx_word == r_sword);

        fr_bad  = 32'(i_in.handle) >= 32'(total);
        fr_reg  = 32'(i_in.handle) >= 32'(r_size0);
        fr_slot = fr_reg ? SLW'(32'(i_in.handle) - 32'(r_size0)) : SLW'(i_in.handle);

        hit_slot   = SLW'({r_word, u_hit_bit});
        hit_handle = HANDLE_W'(32'(hit_slot) + (r_reg ? 32'(r_size0) : 32'd0));

        if (i_cfg.data == '0) begin
            cfg_size0 = SZW'(1);
        end else if (32'(i_cfg.data) > 32'(REGION_SLOTS)) begin
            cfg_size0 = SZW'(REGION_SLOTS);
        end else begin
            cfg_size0 = SZW'(i_cfg.data);
        end
        if (REGIONS < 2) begin
            cfg_size1 = '0;
        end else if (32'(i_cfg.data) > 32'(REGION_SLOTS)) begin
            cfg_size1 = SZW'(REGION_SLOTS);
        end else begin
            cfg_size1 = SZW'(i_cfg.data);
        end

        scan_addr = (r_reg ? AW'(ROWS) : AW'(0)) + AW'(r_word);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_size0      = r_size0;
        n_size1      = r_size1;
        n_cur_reg    = r_cur_reg;
        n_cur_slot   = r_cur_slot;
        n_reg        = r_reg;
        n_word       = r_word;
        n_bit        = r_bit;
        n_sreg       = r_sreg;
        n_sword      = r_sword;
        n_first      = r_first;
        n_last       = r_last;
        n_res_handle = r_res_handle;
        n_res_status = r_res_status;
        n_swp_addr   = r_swp_addr;
        n_swp_end    = r_swp_end;
        n_swp_full   = r_swp_full;
        n_swp_done   = r_swp_done;
        mem_ctl      = '0;
        mem_addr     = scan_addr;
        mem_wdata    = u_data;
        u_mask       = scan_mask;
        u_set        = 1'b0;

        if (cfg_acc) begin
            case (i_cfg.index)
                CFG_REGION0: n_size0 = cfg_size0;
                CFG_REGION1: n_size1 = cfg_size1;
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    case (i_cfg.index)
                        CFG_REGION0: begin
                            n_swp_addr = '0;
                            n_swp_end  = AW'(ROWS - 1);
                            n_swp_full = 1'b0;
                            n_swp_done = 1'b0;
                            n_state    = ST_SWEEP;
                        end
                        CFG_REGION1: begin
                            if (REGIONS >= 2) begin
                                n_swp_addr = AW'(ROWS);
                                n_swp_end  = AW'(DEPTH - 1);
                                n_swp_full = 1'b0;
                                n_swp_done = 1'b0;
                                n_state    = ST_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end else if (in_acc) begin
                    n_res_handle = '0;
                    n_res_status = STAT_OK;
                    case (i_in.mode)
                        MODE_ALLOC: begin
                            n_reg   = st_reg;
                            n_word  = WW'(st_slot >> BIT_W);
                            n_bit   = st_slot[BIT_W-1:0];
                            n_sreg  = st_reg;
                            n_sword = WW'(st_slot >> BIT_W);
                            n_first = 1'b1;
                            n_last  = 1'b0;
                            n_state = ST_RD;
                        end
                        MODE_FREE: begin
                            if (fr_bad) begin
                                n_res_status = STAT_RANGE;
                                n_state      = ST_DONE;
                            end else begin
                                n_reg   = fr_reg;
                                n_word  = WW'(fr_slot >> BIT_W);
                                n_bit   = fr_slot[BIT_W-1:0];
                                n_state = ST_FRD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_swp_addr = '0;
                            n_swp_end  = AW'(DEPTH - 1);
                            n_swp_full = 1'b1;
                            n_swp_done = 1'b1;
                            n_state    = ST_SWEEP;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP: begin
                mem_ctl.we = 1'b1;
                mem_addr   = r_swp_addr;
                mem_wdata  = WORD_ONES;
                n_swp_addr = r_swp_addr + AW'(1);
                if (r_swp_addr == r_swp_end) begin
                    n_state = r_swp_done ? ST_DONE : ST_IDLE;
                end
            end
            ST_RD: begin
                mem_ctl.re = 1'b1;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                if (u_hit) begin
                    mem_ctl.we   = 1'b1;
                    n_cur_reg    = r_reg;
                    n_cur_slot   = hit_slot;
                    n_res_handle = hit_handle;
                    n_res_status = STAT_OK;
                    n_state      = ST_DONE;
                end else if (r_last) begin
                    n_res_handle = '0;
                    n_res_status = STAT_FULL;
                    n_state      = ST_DONE;
                end else begin
                    n_reg   = nx_reg;
                    n_word  = nx_word;
                    n_first = 1'b0;
                    n_last  = nx_last;
                    n_state = ST_RD;
                end
            end
            ST_FRD: begin
                mem_ctl.re = 1'b1;
                n_state    = ST_FWR;
            end
            ST_FWR: begin
                u_set      = 1'b1;
                u_mask     = WORD_ONES;
                mem_ctl.we = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register
    always_comb begin
        out_load     = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);
        n_out_valid  = out_load || (r_out_valid && !o_res.ready);
        n_out_handle = out_load ? r_res_handle : r_out_handle;
        n_out_status = out_load ? r_res_status : r_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_size0     <= SZW'(RST_SIZE0);
            r_size1     <= '0;
            r_cur_reg   <= 1'b0;
            r_cur_slot  <= '0;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_swp_addr  <= '0;
            r_swp_end   <= AW'(DEPTH - 1);
            r_swp_full  <= 1'b1;
            r_swp_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size0     <= n_size0;
            r_size1     <= n_size1;
            r_cur_reg   <= n_cur_reg;
            r_cur_slot  <= n_cur_slot;
            r_first     <= n_first;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_swp_addr  <= n_swp_addr;
            r_swp_end   <= n_swp_end;
            r_swp_full  <= n_swp_full;
            r_swp_done  <= n_swp_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reg        <= n_reg;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_sreg       <= n_sreg;
        r_sword      <= n_sword;
        r_res_handle <= n_res_handle;
        r_res_status <= n_res_status;
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
    end

    a_word_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_word <= lw_cur))
        else $error("scan word beyond region end");

    a_first_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> !(r_first && r_last))
        else $error("scan word marked both first and last");

    a_cursor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EVAL) && u_hit) |=>
            (r_cur_reg ? ({1'b0, r_cur_slot} < r_size1) : ({1'b0, r_cur_slot} < r_size0)))
        else $error("cursor outside its region after alloc");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_swp_addr <= r_swp_end))
        else $error("sweep address past end");

endmodule
